@@ design/qau_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and helpers for the quaternion arithmetic unit.
// No dependencies; every other design file imports this package.
package qau_pkg;

  localparam int CW = 16;               // component width
  localparam int FB = 12;               // fraction bits
  localparam int QUEUE_DEPTH_DEF = 4;   // front-to-back queue entries

  localparam int PW = 2 * CW;           // one product
  localparam int MW = PW + 2;           // sum of four products
  localparam int SW = 2 * CW + 1;       // sum of squares
  localparam int RW = (SW + 1) / 2;     // square root
  localparam int QW = 2 * FB + 1;       // quotient bits
  localparam int NW = CW + 2 * FB;      // dividend
  localparam int LW = 2 * CW + 3;       // value before clamping

  typedef logic signed [CW-1:0] comp_t;

  typedef enum logic [2:0] {
    FN_ADD       = 3'd0,
    FN_SUB       = 3'd1,
    FN_MUL       = 3'd2,
    FN_SCALE     = 3'd3,
    FN_CONJ      = 3'd4,
    FN_NORM      = 3'd5,
    FN_NORMALIZE = 3'd6,
    FN_INVERSE   = 3'd7
  } func_t;

  typedef struct packed {
    func_t func;
    comp_t a_real;
    comp_t a_i;
    comp_t a_j;
    comp_t a_k;
    comp_t b_real;
    comp_t b_i;
    comp_t b_j;
    comp_t b_k;
  } item_t;

  typedef struct packed {
    comp_t r_real;
    comp_t r_i;
    comp_t r_j;
    comp_t r_k;
    logic  saturated;
    logic  zero_divide;
  } result_t;

  // Classified command held in the queue
  typedef struct packed {
    func_t             func;
    logic              divide;
    logic              inverse;
    logic [3:0][CW-1:0] a;
    logic [3:0][CW-1:0] b;
  } cmd_t;

  // Transaction travelling through the square-root stages
  typedef struct packed {
    func_t              func;
    logic               divide;
    logic               inverse;
    logic [3:0][CW-1:0] a;
    logic [SW-1:0]      n2;
    result_t            direct;
  } mid_t;

  // Transaction travelling through the divider stages
  typedef struct packed {
    logic [SW-1:0]         d;
    logic [3:0][SW-1:0]    rem;
    logic [3:0][QW-1:0]    nq;
    logic [3:0]            neg;
    logic                  divide;
    result_t               direct;
  } div_t;

  typedef struct packed {
    comp_t v;
    logic  sat;
  } sat_t;

  localparam logic signed [LW-1:0] CMAX_W = {{(LW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [LW-1:0] CMIN_W = {{(LW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  function automatic sat_t clamp_comp(input logic signed [LW-1:0] v);
    sat_t s;
    if (v > CMAX_W) begin
      s.v   = CMAX_W[CW-1:0];
      s.sat = 1'b1;
    end else if (v < CMIN_W) begin
      s.v   = CMIN_W[CW-1:0];
      s.sat = 1'b1;
    end else begin
      s.v   = v[CW-1:0];
      s.sat = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ design/qau_front.sv @@
`timescale 1ns / 1ps
// Front end: accept items, classify the operation, queue the commands.
// Depends on qau_pkg.
module qau_front import qau_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  input  logic  pop,
  output logic  head_valid,
  output cmd_t  head
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  cmd_t            mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            push;
  logic            take;
  cmd_t            cmd;

  // classify: the square-based operations multiply a by itself
  always_comb begin
    cmd.func    = item.func;
    cmd.divide  = item.func inside {FN_NORMALIZE, FN_INVERSE};
    cmd.inverse = (item.func == FN_INVERSE);
    cmd.a[0]    = item.a_real;
    cmd.a[1]    = item.a_i;
    cmd.a[2]    = item.a_j;
    cmd.a[3]    = item.a_k;
    if (item.func inside {FN_NORM, FN_NORMALIZE, FN_INVERSE}) begin
      cmd.b = cmd.a;
    end else begin
      cmd.b[0] = item.b_real;
      cmd.b[1] = item.b_i;
      cmd.b[2] = item.b_j;
      cmd.b[3] = item.b_k;
    end
  end

  assign item_stall = (count == CNTW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign push       = item_valid && !item_stall;
  assign take       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNTW'(push) - CNTW'(take);
    end
  end

endmodule

@@ design/qau_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined digit-by-digit square root of the sum of squares, one result bit a stage.
// Depends on qau_pkg.
module qau_sqrt import qau_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          src_valid,
  input  mid_t          src,
  output logic          dst_valid,
  output mid_t          dst,
  output logic [RW-1:0] root,
  output logic [RW:0]   rem
);

  logic          st_valid [RW];
  mid_t          st_mid   [RW];
  logic [RW-1:0] st_root  [RW];
  logic [RW:0]   st_rem   [RW];

  for (genvar s = 0; s < RW; s++) begin : g_step
    logic            v_in;
    mid_t            m_in;
    logic [RW-1:0]   root_in;
    logic [RW:0]     rem_in;
    logic [2*RW-1:0] bits;
    logic [RW+2:0]   rem2;
    logic [RW+2:0]   trial;
    logic            hit;

    if (s == 0) begin : g_head
      assign v_in    = src_valid;
      assign m_in    = src;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_tail
      assign v_in    = st_valid[s-1];
      assign m_in    = st_mid[s-1];
      assign root_in = st_root[s-1];
      assign rem_in  = st_rem[s-1];
    end

    assign bits  = (2*RW)'(m_in.n2);
    assign rem2  = {rem_in, bits[2*(RW-1-s) +: 2]};
    assign trial = (RW+3)'({root_in, 2'b01});
    assign hit   = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s] <= 1'b0;
      end else if (adv) begin
        st_valid[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_mid[s]  <= m_in;
        st_root[s] <= {root_in[RW-2:0], hit};
        st_rem[s]  <= hit ? (RW+1)'(rem2 - trial) : (RW+1)'(rem2);
      end
    end
  end

  assign dst_valid = st_valid[RW-1];
  assign dst       = st_mid[RW-1];
  assign root      = st_root[RW-1];
  assign rem       = st_rem[RW-1];

endmodule

@@ design/qau_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, four lanes sharing one divisor, one quotient bit a stage.
// Depends on qau_pkg.
module qau_div import qau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic src_valid,
  input  div_t src,
  output logic dst_valid,
  output div_t dst
);

  logic st_valid [QW];
  div_t st      [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic v_in;
    div_t d_in;
    div_t d_out;

    if (s == 0) begin : g_head
      assign v_in = src_valid;
      assign d_in = src;
    end else begin : g_tail
      assign v_in = st_valid[s-1];
      assign d_in = st[s-1];
    end

    always_comb begin
      logic [SW:0] rem2;
      logic        ge;
      d_out = d_in;
      for (int i = 0; i < 4; i++) begin
        rem2 = {d_in.rem[i], d_in.nq[i][QW-1]};
        ge   = (rem2 >= (SW+1)'(d_in.d));
        d_out.rem[i] = ge ? SW'(rem2 - (SW+1)'(d_in.d)) : SW'(rem2);
        d_out.nq[i]  = {d_in.nq[i][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s] <= 1'b0;
      end else if (adv) begin
        st_valid[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[s] <= d_out;
      end
    end
  end

  assign dst_valid = st_valid[QW-1];
  assign dst       = st[QW-1];

endmodule

@@ design/qau_back.sv @@
`timescale 1ns / 1ps
// Back end: products, sums, square root, division, rounding, clamping, output register.
// Depends on qau_pkg, qau_sqrt and qau_div.
module qau_back import qau_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    src_valid,
  input  cmd_t    src,
  output logic    adv,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam logic signed [MW-1:0] HALF = {{(MW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

  // products and linear results
  logic                 s1_valid;
  func_t                s1_func;
  logic                 s1_divide;
  logic                 s1_inverse;
  logic [3:0][CW-1:0]   s1_a;
  logic signed [PW-1:0] s1_prod [4][4];
  logic signed [CW:0]   s1_lin  [4];
  logic signed [CW:0]   lin_next [4];

  // sums and direct results
  logic                 s2_valid;
  mid_t                 s2_mid;
  mid_t                 mid_next;

  logic                 sq_valid;
  mid_t                 sq_mid;
  logic [RW-1:0]        sq_root;
  logic [RW:0]          sq_rem;

  logic                 s3_valid;
  div_t                 s3;
  div_t                 div_next;

  logic                 dv_valid;
  div_t                 dv;
  result_t              res_next;

  assign adv = !result_valid || !result_stall;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (src.func)
        FN_ADD:  lin_next[i] = (CW+1)'($signed(src.a[i])) + (CW+1)'($signed(src.b[i]));
        FN_SUB:  lin_next[i] = (CW+1)'($signed(src.a[i])) - (CW+1)'($signed(src.b[i]));
        FN_CONJ: lin_next[i] = (i == 0) ? (CW+1)'($signed(src.a[i]))
                                        : -(CW+1)'($signed(src.a[i]));
        default: lin_next[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func    <= src.func;
      s1_divide  <= src.divide;
      s1_inverse <= src.inverse;
      s1_a       <= src.a;
      for (int x = 0; x < 4; x++) begin
        s1_lin[x] <= lin_next[x];
        for (int y = 0; y < 4; y++) begin
          s1_prod[x][y] <= $signed(src.a[x]) * $signed(src.b[y]);
        end
      end
    end
  end

  // Hamilton sums, scaling, sum of squares; round half up and clamp
  always_comb begin
    logic signed [MW-1:0] msum [4];
    logic signed [MW-1:0] rnd;
    logic signed [LW-1:0] val;
    sat_t                 cl [4];
    msum[0] = MW'(s1_prod[0][0]) - MW'(s1_prod[1][1]) - MW'(s1_prod[2][2])
              - MW'(s1_prod[3][3]);
    msum[1] = MW'(s1_prod[0][1]) + MW'(s1_prod[1][0]) + MW'(s1_prod[2][3])
              - MW'(s1_prod[3][2]);
    msum[2] = MW'(s1_prod[0][2]) + MW'(s1_prod[2][0]) + MW'(s1_prod[3][1])
              - MW'(s1_prod[1][3]);
    msum[3] = MW'(s1_prod[0][3]) + MW'(s1_prod[3][0]) + MW'(s1_prod[1][2])
              - MW'(s1_prod[2][1]);
    for (int i = 0; i < 4; i++) begin
      case (s1_func)
        FN_MUL: begin
          rnd = (msum[i] + HALF) >>> FB;
          val = LW'(rnd);
        end
        FN_SCALE: begin
          rnd = (MW'(s1_prod[i][0]) + HALF) >>> FB;
          val = LW'(rnd);
        end
        FN_ADD, FN_SUB, FN_CONJ: begin
          rnd = '0;
          val = LW'(s1_lin[i]);
        end
        default: begin
          rnd = '0;
          val = '0;
        end
      endcase
      cl[i] = clamp_comp(val);
    end
    mid_next.func    = s1_func;
    mid_next.divide  = s1_divide;
    mid_next.inverse = s1_inverse;
    mid_next.a       = s1_a;
    mid_next.n2      = SW'($unsigned(s1_prod[0][0])) + SW'($unsigned(s1_prod[1][1]))
                     + SW'($unsigned(s1_prod[2][2])) + SW'($unsigned(s1_prod[3][3]));
    mid_next.direct.r_real      = cl[0].v;
    mid_next.direct.r_i         = cl[1].v;
    mid_next.direct.r_j         = cl[2].v;
    mid_next.direct.r_k         = cl[3].v;
    mid_next.direct.saturated   = cl[0].sat | cl[1].sat | cl[2].sat | cl[3].sat;
    mid_next.direct.zero_divide = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mid <= mid_next;
    end
  end

  qau_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .src_valid (s2_valid),
    .src       (s2_mid),
    .dst_valid (sq_valid),
    .dst       (sq_mid),
    .root      (sq_root),
    .rem       (sq_rem)
  );

  // round the root, settle the norm, set up the divider lanes
  always_comb begin
    logic [RW-1:0]  nn;
    logic           nz;
    sat_t           ncl;
    logic [CW-1:0]  mag;
    logic [NW-1:0]  x;
    nn  = sq_root + RW'(sq_rem > (RW+1)'(sq_root));
    nz  = (sq_mid.n2 == '0);
    ncl = clamp_comp($signed(LW'(nn)));
    div_next.d      = sq_mid.inverse ? sq_mid.n2 : SW'(nn);
    div_next.divide = sq_mid.divide && !nz;
    div_next.direct = sq_mid.direct;
    for (int i = 0; i < 4; i++) begin
      mag = sq_mid.a[i][CW-1] ? CW'(-$signed(sq_mid.a[i])) : sq_mid.a[i];
      x   = sq_mid.inverse ? {mag, {(2*FB){1'b0}}} : NW'({mag, {FB{1'b0}}});
      div_next.rem[i] = SW'(x[NW-1:QW]);
      div_next.nq[i]  = x[QW-1:0];
      div_next.neg[i] = (sq_mid.inverse && i != 0)
                        ? (!sq_mid.a[i][CW-1] && sq_mid.a[i] != '0)
                        : sq_mid.a[i][CW-1];
    end
    if (sq_mid.func == FN_NORM) begin
      div_next.direct.r_real      = ncl.v;
      div_next.direct.r_i         = '0;
      div_next.direct.r_j         = '0;
      div_next.direct.r_k         = '0;
      div_next.direct.saturated   = ncl.sat;
      div_next.direct.zero_divide = 1'b0;
    end else if (sq_mid.divide) begin
      div_next.direct             = '0;
      div_next.direct.zero_divide = sq_mid.inverse && nz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3 <= div_next;
    end
  end

  qau_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .src_valid (s3_valid),
    .src       (s3),
    .dst_valid (dv_valid),
    .dst       (dv)
  );

  // round half away from zero, apply sign, clamp
  always_comb begin
    logic                 up;
    logic [QW:0]          mag;
    logic signed [LW-1:0] val;
    sat_t                 cl [4];
    for (int i = 0; i < 4; i++) begin
      up    = ({dv.rem[i], 1'b0} >= (SW+1)'(dv.d));
      mag   = (QW+1)'(dv.nq[i]) + (QW+1)'(up);
      val   = $signed(LW'(mag));
      cl[i] = clamp_comp(dv.neg[i] ? -val : val);
    end
    if (dv.divide) begin
      res_next.r_real      = cl[0].v;
      res_next.r_i         = cl[1].v;
      res_next.r_j         = cl[2].v;
      res_next.r_k         = cl[3].v;
      res_next.saturated   = cl[0].sat | cl[1].sat | cl[2].sat | cl[3].sat;
      res_next.zero_divide = 1'b0;
    end else begin
      res_next = dv.direct;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_next;
    end
  end

endmodule

@@ design/quaternion_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// Top level of the quaternion arithmetic unit: front queue plus arithmetic back end.
// Depends on qau_pkg, qau_front and qau_back.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   item_t   (func, a, b)
//   result    out        result_valid / result_stall result_t (r, flags)
//
// One transaction is accepted per cycle while the queue has room, and one result
// leaves per cycle while result_stall is low. Components are Q4.12. The square-root
// stages (one root bit each) are followed by the divider stages (one quotient bit each).
// Every operation takes the same path, so results leave in order.
// rst is synchronous and clears the queue and all stage valid bits.
// A stalled result holds the whole back end; the queue keeps taking
// transactions until it is full, then item_stall rises.
module quaternion_arithmetic_unit import qau_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  cmd_t head;
  logic head_valid;
  logic adv;

  // accept and classify; hold commands until the back end advances
  qau_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .pop        (adv),
    .head_valid (head_valid),
    .head       (head)
  );

  // advance the whole pipeline whenever the output register can drain
  qau_back u_back (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (head_valid),
    .src          (head),
    .adv          (adv),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ design/qau_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the quaternion arithmetic unit, bound to the top level.
// Depends on qau_pkg and quaternion_arithmetic_unit.
module qau_checker import qau_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a zero divisor never also reports a clamp
  a_zdiv_no_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.zero_divide |-> !result.saturated)
    else $error("zero_divide together with saturated");

  // the inverse of zero comes back as zero
  a_zdiv_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.zero_divide |->
      result.r_real == '0 && result.r_i == '0 && result.r_j == '0 && result.r_k == '0)
    else $error("non-zero result with zero_divide");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // reset empties the pipeline and the queue
  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result after reset");

  a_reset_in: assert property (@(posedge clk)
    $past(rst) |-> !item_stall)
    else $error("stall after reset");

endmodule

bind quaternion_arithmetic_unit qau_checker u_checker (.*);
